FILE: rtl/pr_pkg.sv
// ----------------------------------------------------------------------------
// pr_pkg: shared types and codes for the rank engine
// Command and status codes, register map indexes, fixed field widths.
// ----------------------------------------------------------------------------
package pr_pkg;

    localparam int FIELD_W  = 12;
    localparam int NCOUNT_W = 13;
    localparam int DAMP_W   = 16;
    localparam int ITER_W   = 10;
    localparam int TOL_W    = 32;
    localparam int DEG_W    = 15;
    localparam int CHG_W    = 40;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int NODE_IW  = 17;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_RUN  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_DAMPING    = 2'd1;
    localparam logic [1:0] REG_MAX_ITER   = 2'd2;
    localparam logic [1:0] REG_TOLERANCE  = 2'd3;

    localparam logic [DEG_W-1:0] DEG_MAX = '1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/pagerank_power_iteration.sv
// A command's result may wait for the result slot. In a run, the bit-serial
//   divider (one bit per cycle, once per edge used) sets the pass time.
// Throughput: one command at a time; the next is taken while a result waits.
// Reset: synchronous, active low; then the S_CLR state clears the degree and
//   rank memories, during which no command is taken.
// ----------------------------------------------------------------------------
// pagerank_power_iteration: fixed-point rank engine
// Loads directed edges, counts out-degrees, runs power iteration over the
// edge store with two ping-pong rank buffers, and answers rank reads.
// ----------------------------------------------------------------------------
module pagerank_power_iteration #(
    parameter int MAX_NODES      = 4096,
    parameter int MAX_EDGES      = 16384,
    parameter int RANK_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // edge_source[11:0], edge_target[23:12], read_node[35:24]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[1:0], rank[33:2], passes_done[43:34], converged[44]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW  = RANK_FRAC_BITS + 2;
    localparam int NAW = $clog2(MAX_NODES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int IW  = pr_pkg::NODE_IW;
    localparam int DVW = pr_pkg::NODE_IW;
    localparam int SW  = ((RW > pr_pkg::CHG_W) ? RW : pr_pkg::CHG_W) + 1;
    localparam int FW  = pr_pkg::FIELD_W;

    localparam logic [RW-1:0] RANK_ONE = {2'b01, {RANK_FRAC_BITS{1'b0}}};

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_EDGE_WR = 5'd2;
    localparam logic [4:0] S_READ    = 5'd3;
    localparam logic [4:0] S_OUT     = 5'd4;
    localparam logic [4:0] S_INV     = 5'd5;
    localparam logic [4:0] S_CONST   = 5'd6;
    localparam logic [4:0] S_INIT    = 5'd7;
    localparam logic [4:0] S_LOOP    = 5'd8;
    localparam logic [4:0] S_E_RD    = 5'd9;
    localparam logic [4:0] S_E_SRC   = 5'd10;
    localparam logic [4:0] S_E_DEG   = 5'd11;
    localparam logic [4:0] S_E_DIV   = 5'd12;
    localparam logic [4:0] S_E_ACC   = 5'd13;
    localparam logic [4:0] S_N_RD    = 5'd14;
    localparam logic [4:0] S_N_MUL   = 5'd15;
    localparam logic [4:0] S_N_ADD   = 5'd16;
    localparam logic [4:0] S_N_END   = 5'd17;

    // configuration registers
    logic [pr_pkg::NCOUNT_W-1:0] node_count_reg;
    logic [pr_pkg::DAMP_W-1:0]   damping_reg;
    logic [pr_pkg::ITER_W-1:0]   max_iter_reg;
    logic [pr_pkg::TOL_W-1:0]    tolerance_reg;
    logic                        cfg_wr;

    // control and datapath registers
    logic [4:0]                state_reg, state_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic [ECW-1:0]            e_reg, e_next;
    logic [ECW-1:0]            ecount_reg, ecount_next;
    logic                      sel_reg, sel_next;
    logic [pr_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic [pr_pkg::ITER_W-1:0] pass_reg, pass_next;
    logic                      conv_reg, conv_next;
    logic [pr_pkg::CHG_W-1:0]  change_reg, change_next;
    logic [RW-1:0]             inv_reg, inv_next;
    logic [RW-1:0]             c_reg, c_next;
    logic [RW+15:0]            prod_reg, prod_next;
    logic [RW-1:0]             cu_reg, cu_next;
    logic [FW-1:0]             src_reg, src_next;
    logic [FW-1:0]             tgt_reg, tgt_next;
    logic [1:0]                status_reg, status_next;
    logic [31:0]               rank_reg, rank_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [47:0]               m_tdata_reg, m_tdata_next;

    // memory ports
    logic                 edge_we;
    logic [EAW-1:0]       edge_waddr, edge_raddr;
    logic [2*FW-1:0]      edge_wdata, edge_rdata;
    logic                 deg_we;
    logic [NAW-1:0]       deg_waddr, deg_raddr;
    logic [pr_pkg::DEG_W-1:0] deg_wdata, deg_rdata;
    logic                 cur_we, nxt_we;
    logic [NAW-1:0]       cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
    logic [RW-1:0]        cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;
    logic                 a_we, b_we;
    logic [NAW-1:0]       a_waddr, b_waddr, a_raddr, b_raddr;
    logic [RW-1:0]        a_wdata, b_wdata, a_rdata, b_rdata;

    // divider
    logic                 div_start;
    logic [RW-1:0]        div_dividend, div_q;
    logic [DVW-1:0]       div_divisor;
    pr_pkg::div_stat_t    div_stat;

    // datapath helpers
    logic [IW-1:0]        n_act;
    logic [FW-1:0]        in_src, in_tgt, in_node, e_src, e_tgt;
    logic [RW+16:0]       cprod;
    logic [RW:0]          asum, nsum;
    logic [RW-1:0]        nx, delta;
    logic [SW-1:0]        csum;

    assign in_src  = s_tdata[11:0];
    assign in_tgt  = s_tdata[23:12];
    assign in_node = s_tdata[35:24];
    assign e_src   = edge_rdata[FW-1:0];
    assign e_tgt   = edge_rdata[2*FW-1:FW];

    // Oversized node counts act as MAX_NODES.
    assign n_act = (IW'(node_count_reg) > IW'(MAX_NODES)) ? IW'(MAX_NODES)
                                                          : IW'(node_count_reg);

    // ------------------------------------------------------------------
    // Register port: writes land on the access phase, reads are direct.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
            damping_reg    <= 16'd55706;
            max_iter_reg   <= 10'd20;
            tolerance_reg  <= 32'd107;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pr_pkg::REG_NODE_COUNT: node_count_reg <= pwdata[pr_pkg::NCOUNT_W-1:0];
                pr_pkg::REG_DAMPING:    damping_reg    <= pwdata[pr_pkg::DAMP_W-1:0];
                pr_pkg::REG_MAX_ITER:   max_iter_reg   <= pwdata[pr_pkg::ITER_W-1:0];
                pr_pkg::REG_TOLERANCE:  tolerance_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pr_pkg::REG_NODE_COUNT: prdata = 32'(node_count_reg);
            pr_pkg::REG_DAMPING:    prdata = 32'(damping_reg);
            pr_pkg::REG_MAX_ITER:   prdata = 32'(max_iter_reg);
            pr_pkg::REG_TOLERANCE:  prdata = tolerance_reg;
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories: edge store, out-degree table, two rank buffers.
    // sel_reg picks which buffer holds the current ranks.
    // ------------------------------------------------------------------
    pr_ram #(.DEPTH(MAX_EDGES), .WIDTH(2 * FW), .AW(EAW)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    pr_ram #(.DEPTH(MAX_NODES), .WIDTH(pr_pkg::DEG_W), .AW(NAW)) u_deg_ram (
        .aclk  (aclk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    pr_ram #(.DEPTH(MAX_NODES), .WIDTH(RW), .AW(NAW)) u_rank_a_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    pr_ram #(.DEPTH(MAX_NODES), .WIDTH(RW), .AW(NAW)) u_rank_b_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Map the current/next view onto the physical buffers.
    assign a_we      = sel_reg ? nxt_we    : cur_we;
    assign a_waddr   = sel_reg ? nxt_waddr : cur_waddr;
    assign a_wdata   = sel_reg ? nxt_wdata : cur_wdata;
    assign a_raddr   = sel_reg ? nxt_raddr : cur_raddr;
    assign b_we      = sel_reg ? cur_we    : nxt_we;
    assign b_waddr   = sel_reg ? cur_waddr : nxt_waddr;
    assign b_wdata   = sel_reg ? cur_wdata : nxt_wdata;
    assign b_raddr   = sel_reg ? cur_raddr : nxt_raddr;
    assign cur_rdata = sel_reg ? b_rdata   : a_rdata;
    assign nxt_rdata = sel_reg ? a_rdata   : b_rdata;

    // Shared divider: 1/N at run start, rank/out-degree per edge.
    pr_div #(.DW(RW), .VW(DVW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // Arithmetic
    // ------------------------------------------------------------------
    // c = floor(inv * (1 - d)) with d in Q0.16
    assign cprod = (RW+17)'(inv_reg) * (RW+17)'(17'h10000 - 17'(damping_reg));
    // edge contribution, saturating
    assign asum  = (RW+1)'(nxt_rdata) + (RW+1)'(div_q);
    // damped rank plus teleport term, saturating
    assign nsum  = (RW+1)'(prod_reg[RW+15:16]) + (RW+1)'(c_reg);
    assign nx    = nsum[RW] ? '1 : nsum[RW-1:0];
    assign delta = (nx > cu_reg) ? (nx - cu_reg) : (cu_reg - nx);
    assign csum  = SW'(change_reg) + SW'(delta);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        e_next        = e_reg;
        ecount_next   = ecount_reg;
        sel_next      = sel_reg;
        iter_next     = iter_reg;
        pass_next     = pass_reg;
        conv_next     = conv_reg;
        change_next   = change_reg;
        inv_next      = inv_reg;
        c_next        = c_reg;
        prod_next     = prod_reg;
        cu_next       = cu_reg;
        src_next      = src_reg;
        tgt_next      = tgt_reg;
        status_next   = status_reg;
        rank_next     = rank_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;

        edge_we    = 1'b0;
        edge_waddr = ecount_reg[EAW-1:0];
        edge_wdata = {in_tgt, in_src};
        edge_raddr = e_reg[EAW-1:0];
        deg_we     = 1'b0;
        deg_waddr  = NAW'(src_reg);
        deg_wdata  = (deg_rdata == pr_pkg::DEG_MAX) ? deg_rdata : deg_rdata + 1'b1;
        deg_raddr  = (state_reg == S_IDLE) ? NAW'(in_src) : NAW'(e_src);
        cur_we     = 1'b0;
        cur_waddr  = idx_reg[NAW-1:0];
        cur_wdata  = '0;
        nxt_we     = 1'b0;
        nxt_waddr  = idx_reg[NAW-1:0];
        nxt_wdata  = '0;
        cur_raddr  = idx_reg[NAW-1:0];
        nxt_raddr  = idx_reg[NAW-1:0];

        div_start    = 1'b0;
        div_dividend = cur_rdata;
        div_divisor  = DVW'(deg_rdata);

        case (state_reg)
            S_CLR: begin
                deg_we    = 1'b1;
                deg_waddr = idx_reg[NAW-1:0];
                deg_wdata = '0;
                cur_we    = 1'b1;
                nxt_we    = 1'b1;
                if (idx_reg == IW'(MAX_NODES - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                cur_raddr = NAW'(in_node);
                if (s_tvalid) begin
                    src_next    = in_src;
                    tgt_next    = in_tgt;
                    status_next = pr_pkg::ST_OK;
                    rank_next   = '0;
                    state_next  = S_OUT;
                    case (s_tuser)
                        pr_pkg::FUNC_ADD: begin
                            if (IW'(in_src) >= n_act || IW'(in_tgt) >= n_act) begin
                                status_next = pr_pkg::ST_RANGE;
                            end else if (ecount_reg >= ECW'(MAX_EDGES)) begin
                                status_next = pr_pkg::ST_FULL;
                            end else begin
                                edge_we     = 1'b1;
                                ecount_next = ecount_reg + 1'b1;
                                state_next  = S_EDGE_WR;
                            end
                        end
                        pr_pkg::FUNC_RUN: begin
                            if (n_act == '0) begin
                                status_next = pr_pkg::ST_NONE;
                            end else begin
                                div_start    = 1'b1;
                                div_dividend = RANK_ONE;
                                div_divisor  = n_act;
                                state_next   = S_INV;
                            end
                        end
                        pr_pkg::FUNC_READ: begin
                            if (n_act == '0) begin
                                status_next = pr_pkg::ST_NONE;
                            end else if (IW'(in_node) >= n_act) begin
                                status_next = pr_pkg::ST_RANGE;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EDGE_WR: begin
                // degree read issued at accept; bump it, saturating
                deg_we     = 1'b1;
                state_next = S_OUT;
            end
            S_READ: begin
                rank_next  = 32'(cur_rdata);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, conv_reg, pass_reg, rank_reg, status_reg};
                    state_next    = S_IDLE;
                end
            end
            S_INV: begin
                if (div_stat.done) begin
                    inv_next   = div_q;
                    state_next = S_CONST;
                end
            end
            S_CONST: begin
                c_next      = cprod[RW+15:16];
                idx_next    = '0;
                conv_next   = 1'b0;
                change_next = '0;
                pass_next   = '0;
                iter_next   = pr_pkg::ITER_W'(1);
                state_next  = S_INIT;
            end
            S_INIT: begin
                // wipe both buffers, seed current ranks with 1/N
                cur_we    = 1'b1;
                cur_wdata = (idx_reg < n_act) ? inv_reg : '0;
                nxt_we    = 1'b1;
                if (idx_reg == IW'(MAX_NODES - 1)) begin
                    state_next = S_LOOP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_LOOP: begin
                if (iter_reg < max_iter_reg) begin
                    e_next     = '0;
                    state_next = S_E_RD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_E_RD: begin
                if (e_reg >= ecount_reg) begin
                    idx_next    = '0;
                    change_next = '0;
                    state_next  = S_N_RD;
                end else begin
                    state_next = S_E_SRC;
                end
            end
            S_E_SRC: begin
                cur_raddr = NAW'(e_src);
                src_next  = e_src;
                tgt_next  = e_tgt;
                // skip edges left over from a larger node count
                if (IW'(e_src) < n_act && IW'(e_tgt) < n_act) begin
                    state_next = S_E_DEG;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_E_RD;
                end
            end
            S_E_DEG: begin
                if (deg_rdata == '0) begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_E_RD;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_E_DIV;
                end
            end
            S_E_DIV: begin
                nxt_raddr = NAW'(tgt_reg);
                if (div_stat.done) begin
                    state_next = S_E_ACC;
                end
            end
            S_E_ACC: begin
                nxt_we     = 1'b1;
                nxt_waddr  = NAW'(tgt_reg);
                nxt_wdata  = asum[RW] ? '1 : asum[RW-1:0];
                e_next     = e_reg + 1'b1;
                state_next = S_E_RD;
            end
            S_N_RD: begin
                if (idx_reg >= n_act) begin
                    state_next = S_N_END;
                end else begin
                    state_next = S_N_MUL;
                end
            end
            S_N_MUL: begin
                prod_next  = (RW+16)'(nxt_rdata) * (RW+16)'(damping_reg);
                cu_next    = cur_rdata;
                state_next = S_N_ADD;
            end
            S_N_ADD: begin
                // new rank into next buffer; old one cleared for the swap
                nxt_we      = 1'b1;
                nxt_wdata   = nx;
                cur_we      = 1'b1;
                change_next = (csum[SW-1:pr_pkg::CHG_W] != '0) ? '1
                                                               : csum[pr_pkg::CHG_W-1:0];
                idx_next    = idx_reg + 1'b1;
                state_next  = S_N_RD;
            end
            S_N_END: begin
                sel_next  = ~sel_reg;
                pass_next = pass_reg + 1'b1;
                if (change_reg < pr_pkg::CHG_W'(tolerance_reg)) begin
                    conv_next  = 1'b1;
                    state_next = S_OUT;
                end else begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_LOOP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            idx_reg      <= '0;
            ecount_reg   <= '0;
            sel_reg      <= 1'b0;
            pass_reg     <= '0;
            conv_reg     <= 1'b0;
            change_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            ecount_reg   <= ecount_next;
            sel_reg      <= sel_next;
            pass_reg     <= pass_next;
            conv_reg     <= conv_next;
            change_reg   <= change_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        e_reg       <= e_next;
        iter_reg    <= iter_next;
        inv_reg     <= inv_next;
        c_reg       <= c_next;
        prod_reg    <= prod_next;
        cu_reg      <= cu_next;
        src_reg     <= src_next;
        tgt_reg     <= tgt_next;
        status_reg  <= status_next;
        rank_reg    <= rank_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_edge_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ecount_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while first in progress");
`endif

endmodule

FILE: rtl/pr_div.sv
// ----------------------------------------------------------------------------
// pr_div: restoring divider
// One quotient bit per cycle; quotient held until the next start.
// ----------------------------------------------------------------------------
module pr_div #(
    parameter int DW = 32,
    parameter int VW = 17
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [VW-1:0]     divisor,
    output pr_pkg::div_stat_t stat,
    output logic [DW-1:0]     quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(DW);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[VW-1:0] : trial[VW-1:0];
            quo_next  = {quo_reg[DW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

FILE: rtl/pr_ram.sv
// ----------------------------------------------------------------------------
// pr_ram: simple dual-port synchronous memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int AW    = 12
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
